### rtl/rnf_pkg.sv
// ----------------------------------------------------------------------------
// rnf_pkg
// Shared types, constants and character helpers for the radix number
// formatter: flag positions, divider sizing and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package rnf_pkg;

  // Flag bit positions within the flags field.
  localparam int FL_ZERO   = 0;
  localparam int FL_SIGNED = 1;
  localparam int FL_PLUS   = 2;
  localparam int FL_SPACE  = 3;
  localparam int FL_LEFT   = 4;
  localparam int FL_PREFIX = 5;
  localparam int FL_LOWER  = 6;

  localparam int ValueW    = 32;
  localparam int RadixW    = 6;
  localparam int FieldW    = 6;
  localparam int FlagsW    = 7;
  localparam int CharW     = 8;
  localparam int DigitW    = 6;
  localparam int DigitAddrW = 5;

  // The divider consumes this many dividend bits per cycle.
  localparam int DivChunk  = 8;
  localparam int DivSteps  = ValueW / DivChunk;
  localparam int DivStepW  = $clog2(DivSteps);

  localparam logic [RadixW-1:0] RadixMin = 6'd2;
  localparam logic [RadixW-1:0] RadixMax = 6'd36;
  localparam logic [RadixW-1:0] RadixOct = 6'd8;
  localparam logic [RadixW-1:0] RadixHex = 6'd16;

  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChPlus  = 8'h2B;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChUpX   = 8'h58;
  localparam logic [CharW-1:0] ChLowX  = 8'h78;
  localparam logic [CharW-1:0] ChNone  = 8'h00;

  typedef enum logic [2:0] {
    CS_SPACE,
    CS_ZERO,
    CS_SIGN,
    CS_X,
    CS_DIGIT,
    CS_BAD
  } char_sel_t;

  typedef struct packed {
    logic      capture;
    logic      div_start;
    logic      plan;
    logic      emit;
    char_sel_t emit_sel;
    logic      emit_last;
    logic      dec_pad;
    logic      dec_pzero;
    logic      dec_idx;
  } cmd_t;

  typedef struct packed {
    logic       in_bad;
    logic       div_done;
    logic       quot_zero;
    logic       count_full;
    logic       pad_zero;
    logic       pad_one;
    logic       pzero_zero;
    logic       idx_last;
    logic       has_sign;
    logic [1:0] pfx_len;
    logic       lead_space;
    logic       lead_zero;
    logic       left;
    logic       out_free;
  } status_t;

  // Digit value to ASCII; values past the last symbol wrap around the set.
  function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] d,
                                                  input logic lower);
    logic [DigitW-1:0] dm;
    dm = (d >= 6'd36) ? 6'(d - 6'd36) : d;
    if (dm < 6'd10) begin
      digit_char = ChZero + {2'b00, dm};
    end else if (lower) begin
      digit_char = 8'h61 + {2'b00, 6'(dm - 6'd10)};
    end else begin
      digit_char = 8'h41 + {2'b00, 6'(dm - 6'd10)};
    end
  endfunction

endpackage

`default_nettype wire

### rtl/radix_number_formatter_top.sv
// ----------------------------------------------------------------------------
// radix_number_formatter_top
// Formats a 32-bit integer in radix 2 to 36 as a stream of ASCII characters.
// ----------------------------------------------------------------------------
// One item at a time: an item with a bad radix goes to a bad-radix state
// that gives its single error result once the output register is free.
// Otherwise the value is divided by the radix once per digit in a divider
// that takes 8 dividend bits a cycle; each digit takes a start, the divide
// steps and a step that stores the digit. After a planning step the
// characters leave at one per cycle while the output is not stalled; print
// phases that have nothing to show, or have just run out, give no character.
// The last character of an item may still wait in the output register while
// the next item is accepted.
`default_nettype none

module radix_number_formatter_top #(
  parameter int MAX_FIELD = 48
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [rnf_pkg::ValueW-1:0] in_value,
  input  wire logic [rnf_pkg::RadixW-1:0] in_radix,
  input  wire logic [rnf_pkg::FieldW-1:0] in_field_width,
  input  wire logic [rnf_pkg::FieldW-1:0] in_min_digits,
  input  wire logic [rnf_pkg::FlagsW-1:0] in_flags,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [rnf_pkg::CharW-1:0]       out_char,
  output logic                            out_last,
  output logic                            out_bad_radix
);

  rnf_pkg::cmd_t    cmd;
  rnf_pkg::status_t st;

  rnf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  rnf_datapath #(
    .MAX_FIELD (MAX_FIELD)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_value),
    .in_radix       (in_radix),
    .in_field_width (in_field_width),
    .in_min_digits  (in_min_digits),
    .in_flags       (in_flags),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_char       (out_char),
    .out_last       (out_last),
    .out_bad_radix  (out_bad_radix),
    .cmd            (cmd),
    .st             (st)
  );

endmodule

`default_nettype wire

### rtl/rnf_divider.sv
// ----------------------------------------------------------------------------
// rnf_divider
// Iterative restoring divider of a 32-bit value by a small radix. It takes
// one slice of dividend bits per cycle and returns quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module rnf_divider (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [rnf_pkg::ValueW-1:0]    dividend,
  input  wire logic [rnf_pkg::RadixW-1:0]    divisor,
  output logic                               done,
  output logic [rnf_pkg::ValueW-1:0]         quotient,
  output logic [rnf_pkg::DigitW-1:0]         remainder
);

  logic [rnf_pkg::ValueW-1:0]   dvd_r;
  logic [rnf_pkg::DigitW-1:0]   rem_r;
  logic [rnf_pkg::RadixW-1:0]   div_r;
  logic [rnf_pkg::DivStepW-1:0] step_r;
  logic                         busy_r;
  logic                         done_r;

  logic [rnf_pkg::DigitW-1:0]   rem_nxt;
  logic [rnf_pkg::DivChunk-1:0] qbits;

  // Shift the top slice of the dividend into the partial remainder, one bit
  // per step. The partial remainder always stays below the divisor.
  always_comb begin
    logic [rnf_pkg::DigitW:0] t;
    rem_nxt = rem_r;
    qbits   = '0;
    for (int k = 0; k < rnf_pkg::DivChunk; k++) begin
      t = {rem_nxt, dvd_r[rnf_pkg::ValueW-1-k]};
      if (t >= {1'b0, div_r}) begin
        rem_nxt = rnf_pkg::DigitW'(t - {1'b0, div_r});
        qbits[rnf_pkg::DivChunk-1-k] = 1'b1;
      end else begin
        rem_nxt = t[rnf_pkg::DigitW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == rnf_pkg::DivStepW'(rnf_pkg::DivSteps - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[rnf_pkg::ValueW-rnf_pkg::DivChunk-1:0], qbits};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

### rtl/rnf_datapath.sv
// ----------------------------------------------------------------------------
// rnf_datapath
// Holds the captured item, drives the divider, stores the digits, keeps the
// padding counters and builds each character in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rnf_datapath #(
  parameter int MAX_FIELD = 48
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [rnf_pkg::ValueW-1:0]    in_value,
  input  wire logic [rnf_pkg::RadixW-1:0]    in_radix,
  input  wire logic [rnf_pkg::FieldW-1:0]    in_field_width,
  input  wire logic [rnf_pkg::FieldW-1:0]    in_min_digits,
  input  wire logic [rnf_pkg::FlagsW-1:0]    in_flags,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [rnf_pkg::CharW-1:0]          out_char,
  output logic                               out_last,
  output logic                               out_bad_radix,
  input  wire rnf_pkg::cmd_t                 cmd,
  output rnf_pkg::status_t                   st
);

  localparam int PadW = $clog2(MAX_FIELD + 1);
  localparam logic [rnf_pkg::FieldW-1:0] MaxF = rnf_pkg::FieldW'(MAX_FIELD);

  // Captured item.
  logic [rnf_pkg::ValueW-1:0] val_r;
  logic [rnf_pkg::RadixW-1:0] radix_r;
  logic [rnf_pkg::FieldW-1:0] width_r;
  logic [rnf_pkg::FieldW-1:0] prec_r;
  logic [rnf_pkg::CharW-1:0]  sign_char_r;
  logic                       has_sign_r;
  logic [1:0]                 pfx_len_r;
  logic                       lower_r;
  logic                       left_r;
  logic                       zero_r;

  // Digits and counters.
  logic [rnf_pkg::DigitW-1:0] digit_store [2**rnf_pkg::DigitAddrW];
  logic [rnf_pkg::DigitW-1:0] count_r;
  logic [rnf_pkg::DigitW-1:0] idx_r;
  logic [rnf_pkg::FieldW-1:0] pzero_r;
  logic [PadW-1:0]            pad_r;

  // Output register.
  logic                       out_valid_r;
  logic [rnf_pkg::CharW-1:0]  out_char_r;
  logic                       out_last_r;
  logic                       out_bad_r;

  logic                       div_done;
  logic [rnf_pkg::ValueW-1:0] div_quot;
  logic [rnf_pkg::DigitW-1:0] div_rem;

  rnf_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (val_r),
    .divisor   (radix_r),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // Capture-time decode of the incoming item.
  logic                       neg;
  logic [rnf_pkg::ValueW-1:0] val_cap;
  logic [rnf_pkg::CharW-1:0]  sign_cap;
  logic                       has_sign_cap;
  logic [1:0]                 pfx_cap;

  always_comb begin
    neg     = in_flags[rnf_pkg::FL_SIGNED] && in_value[rnf_pkg::ValueW-1];
    val_cap = neg ? (rnf_pkg::ValueW'(0) - in_value) : in_value;
    has_sign_cap = 1'b1;
    if (neg) begin
      sign_cap = rnf_pkg::ChMinus;
    end else if (in_flags[rnf_pkg::FL_PLUS]) begin
      sign_cap = rnf_pkg::ChPlus;
    end else if (in_flags[rnf_pkg::FL_SPACE]) begin
      sign_cap = rnf_pkg::ChSpace;
    end else begin
      sign_cap     = rnf_pkg::ChNone;
      has_sign_cap = 1'b0;
    end
    if (in_flags[rnf_pkg::FL_PREFIX] && in_radix == rnf_pkg::RadixHex) begin
      pfx_cap = 2'd2;
    end else if (in_flags[rnf_pkg::FL_PREFIX] && in_radix == rnf_pkg::RadixOct) begin
      pfx_cap = 2'd1;
    end else begin
      pfx_cap = 2'd0;
    end
  end

  // Padding plan once all digits are known.
  logic [rnf_pkg::FieldW-1:0] prec_eff;
  logic signed [7:0]          size_s;
  logic [PadW-1:0]            pad_plan;

  always_comb begin
    prec_eff = (count_r > prec_r) ? count_r : prec_r;
    size_s   = $signed(8'(width_r)) - $signed(8'(has_sign_r))
             - $signed(8'(pfx_len_r)) - $signed(8'(prec_eff));
    pad_plan = (size_s > 8'sd0) ? size_s[PadW-1:0] : '0;
  end

  logic [rnf_pkg::DigitAddrW-1:0] rd_addr;
  logic [rnf_pkg::CharW-1:0]      char_nxt;

  assign rd_addr = rnf_pkg::DigitAddrW'(idx_r - 6'd1);

  // Characters that do not come from the digit store.
  always_comb begin
    case (cmd.emit_sel)
      rnf_pkg::CS_SPACE: char_nxt = rnf_pkg::ChSpace;
      rnf_pkg::CS_ZERO:  char_nxt = rnf_pkg::ChZero;
      rnf_pkg::CS_SIGN:  char_nxt = sign_char_r;
      rnf_pkg::CS_X:     char_nxt = lower_r ? rnf_pkg::ChLowX : rnf_pkg::ChUpX;
      rnf_pkg::CS_BAD:   char_nxt = rnf_pkg::ChNone;
      default:           char_nxt = rnf_pkg::ChNone;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      val_r       <= val_cap;
      radix_r     <= in_radix;
      width_r     <= (in_field_width > MaxF) ? MaxF : in_field_width;
      prec_r      <= (in_min_digits > MaxF) ? MaxF : in_min_digits;
      sign_char_r <= sign_cap;
      has_sign_r  <= has_sign_cap;
      pfx_len_r   <= pfx_cap;
      lower_r     <= in_flags[rnf_pkg::FL_LOWER];
      left_r      <= in_flags[rnf_pkg::FL_LEFT];
      zero_r      <= in_flags[rnf_pkg::FL_ZERO] && !in_flags[rnf_pkg::FL_LEFT];
    end else if (div_done) begin
      val_r <= div_quot;
    end
    if (div_done) begin
      digit_store[count_r[rnf_pkg::DigitAddrW-1:0]] <= div_rem;
    end
    if (cmd.plan) begin
      pzero_r <= prec_eff - count_r;
    end else if (cmd.dec_pzero) begin
      pzero_r <= pzero_r - 1'b1;
    end
    if (cmd.emit) begin
      if (cmd.emit_sel == rnf_pkg::CS_DIGIT) begin
        out_char_r <= rnf_pkg::digit_char(digit_store[rd_addr], lower_r);
      end else begin
        out_char_r <= char_nxt;
      end
      out_last_r <= cmd.emit_last;
      out_bad_r  <= (cmd.emit_sel == rnf_pkg::CS_BAD);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      pad_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        count_r <= '0;
      end else if (div_done) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.plan) begin
        idx_r <= count_r;
        pad_r <= pad_plan;
      end else begin
        if (cmd.dec_idx) begin
          idx_r <= idx_r - 1'b1;
        end
        if (cmd.dec_pad) begin
          pad_r <= pad_r - 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    st.in_bad     = (in_radix < rnf_pkg::RadixMin) || (in_radix > rnf_pkg::RadixMax);
    st.div_done   = div_done;
    st.quot_zero  = (div_quot == '0);
    st.count_full = (count_r == rnf_pkg::DigitW'(rnf_pkg::ValueW - 1));
    st.pad_zero   = (pad_r == '0);
    st.pad_one    = (pad_r == PadW'(1));
    st.pzero_zero = (pzero_r == '0);
    st.idx_last   = (idx_r == 6'd1);
    st.has_sign   = has_sign_r;
    st.pfx_len    = pfx_len_r;
    st.lead_space = !zero_r && !left_r;
    st.lead_zero  = zero_r;
    st.left       = left_r;
    st.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid     = out_valid_r;
  assign out_char      = out_char_r;
  assign out_last      = out_last_r;
  assign out_bad_radix = out_bad_r;

endmodule

`default_nettype wire

### rtl/rnf_ctrl.sv
// ----------------------------------------------------------------------------
// rnf_ctrl
// Sequencer for one item: capture, repeated radix division, padding plan,
// then the character phases in print order; a bad radix gives an error.
// ----------------------------------------------------------------------------
`default_nettype none

module rnf_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire rnf_pkg::status_t st,
  output rnf_pkg::cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_BAD,
    S_DIV_START,
    S_DIV_WAIT,
    S_PLAN,
    S_LSPACE,
    S_SIGN,
    S_PFX0,
    S_PFXX,
    S_LZERO,
    S_PZERO,
    S_DIGIT,
    S_TSPACE
  } state_t;

  state_t state_r, state_nxt;
  logic   ready_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.emit_sel  = rnf_pkg::CS_ZERO;
    case (state_r)
      S_IDLE: begin
        if (in_valid && ready_r) begin
          cmd.capture = 1'b1;
          state_nxt   = st.in_bad ? S_BAD : S_DIV_START;
        end
      end
      S_BAD: begin
        if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = rnf_pkg::CS_BAD;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (st.div_done) begin
          state_nxt = (st.quot_zero || st.count_full) ? S_PLAN : S_DIV_START;
        end
      end
      S_PLAN: begin
        cmd.plan  = 1'b1;
        state_nxt = S_LSPACE;
      end
      S_LSPACE: begin
        if (!st.lead_space || st.pad_zero) begin
          state_nxt = S_SIGN;
        end else if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = rnf_pkg::CS_SPACE;
          cmd.dec_pad  = 1'b1;
        end
      end
      S_SIGN: begin
        if (!st.has_sign) begin
          state_nxt = S_PFX0;
        end else if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = rnf_pkg::CS_SIGN;
          state_nxt    = S_PFX0;
        end
      end
      S_PFX0: begin
        if (st.pfx_len == 2'd0) begin
          state_nxt = S_LZERO;
        end else if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = rnf_pkg::CS_ZERO;
          state_nxt    = (st.pfx_len == 2'd2) ? S_PFXX : S_LZERO;
        end
      end
      S_PFXX: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = rnf_pkg::CS_X;
          state_nxt    = S_LZERO;
        end
      end
      S_LZERO: begin
        if (!st.lead_zero || st.pad_zero) begin
          state_nxt = S_PZERO;
        end else if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = rnf_pkg::CS_ZERO;
          cmd.dec_pad  = 1'b1;
        end
      end
      S_PZERO: begin
        if (st.pzero_zero) begin
          state_nxt = S_DIGIT;
        end else if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = rnf_pkg::CS_ZERO;
          cmd.dec_pzero = 1'b1;
        end
      end
      S_DIGIT: begin
        if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = rnf_pkg::CS_DIGIT;
          cmd.emit_last = st.idx_last && (!st.left || st.pad_zero);
          cmd.dec_idx   = 1'b1;
          if (st.idx_last) begin
            state_nxt = (st.left && !st.pad_zero) ? S_TSPACE : S_IDLE;
          end
        end
      end
      S_TSPACE: begin
        if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = rnf_pkg::CS_SPACE;
          cmd.emit_last = st.pad_one;
          cmd.dec_pad   = 1'b1;
          if (st.pad_one) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ready_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = ready_r;

endmodule

`default_nettype wire

### rtl/rnf_checker.sv
// ----------------------------------------------------------------------------
// rnf_checker
// Port-level checks of the formatter's result stream, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module rnf_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic [rnf_pkg::RadixW-1:0] in_radix,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [rnf_pkg::CharW-1:0]  out_char,
  input wire logic                       out_last,
  input wire logic                       out_bad_radix
);

  // An error result is a single, final item with a null character.
  a_bad_is_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_radix |-> out_last && out_char == rnf_pkg::ChNone)
    else $error("error result is not a lone null final item");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last)
      && $stable(out_bad_radix))
    else $error("stalled result changed");

  // While a character that is not the last one waits, no new item is taken.
  a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken while a run is still being emitted");

  // A bad radix accepted while no result is waiting is followed by its error result.
  a_bad_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid
      && (in_radix < rnf_pkg::RadixMin || in_radix > rnf_pkg::RadixMax)
      |-> ##2 (out_valid && out_bad_radix))
    else $error("bad radix result missing");

endmodule

bind radix_number_formatter_top rnf_checker u_rnf_checker (.*);

`default_nettype wire

### tb/sv/tb_radix_number_formatter_top.sv
// ----------------------------------------------------------------------------
// tb_radix_number_formatter_top
// Self-checking bench for the radix number formatter. A short table of
// directed numbers comes first, then several hundred random numbers. Each
// accepted number is turned into its expected characters (from the table
// or by a behavioral formatter in this file), and each output character
// is compared in order. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_radix_number_formatter_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_FIELD      = 48;
  localparam int RESET_CYCLES   = 10;
  localparam int RANDOM_ITEMS   = 305;
  localparam int DRAIN_CYCLES   = 250;
  // Sized for the slowest case, a radix 2 number with 49 characters, each of
  // which may wait out a receiver stall, plus a sender gap, for all 330 items.
  localparam int TIMEOUT_CYCLES = 3_000_000;

  localparam logic [rnf_pkg::FlagsW-1:0] F_NONE   = '0;
  localparam logic [rnf_pkg::FlagsW-1:0] F_ZERO   =
    rnf_pkg::FlagsW'(1 << rnf_pkg::FL_ZERO);
  localparam logic [rnf_pkg::FlagsW-1:0] F_SIGNED =
    rnf_pkg::FlagsW'(1 << rnf_pkg::FL_SIGNED);
  localparam logic [rnf_pkg::FlagsW-1:0] F_PLUS   =
    rnf_pkg::FlagsW'(1 << rnf_pkg::FL_PLUS);
  localparam logic [rnf_pkg::FlagsW-1:0] F_SPACE  =
    rnf_pkg::FlagsW'(1 << rnf_pkg::FL_SPACE);
  localparam logic [rnf_pkg::FlagsW-1:0] F_LEFT   =
    rnf_pkg::FlagsW'(1 << rnf_pkg::FL_LEFT);
  localparam logic [rnf_pkg::FlagsW-1:0] F_PREFIX =
    rnf_pkg::FlagsW'(1 << rnf_pkg::FL_PREFIX);
  localparam logic [rnf_pkg::FlagsW-1:0] F_LOWER  =
    rnf_pkg::FlagsW'(1 << rnf_pkg::FL_LOWER);
  localparam logic [rnf_pkg::FlagsW-1:0] F_ALL    = '1;

  localparam logic [rnf_pkg::CharW-1:0] CH_UP_A  = 8'h41;
  localparam logic [rnf_pkg::CharW-1:0] CH_LOW_A = 8'h61;

  typedef enum int {
    CHK_PREDICT,
    CHK_TEXT,
    CHK_BAD_RADIX
  } check_kind_t;

  typedef struct {
    logic [rnf_pkg::ValueW-1:0] value;
    logic [rnf_pkg::RadixW-1:0] radix;
    logic [rnf_pkg::FieldW-1:0] width;
    logic [rnf_pkg::FieldW-1:0] digits;
    logic [rnf_pkg::FlagsW-1:0] flags;
  } fmt_req_t;

  typedef struct {
    logic [rnf_pkg::ValueW-1:0] value;
    logic [rnf_pkg::RadixW-1:0] radix;
    logic [rnf_pkg::FieldW-1:0] width;
    logic [rnf_pkg::FieldW-1:0] digits;
    logic [rnf_pkg::FlagsW-1:0] flags;
    check_kind_t                kind;
    string                      text;
  } dir_row_t;

  typedef struct {
    logic [rnf_pkg::CharW-1:0] ch;
    logic                      last;
    logic                      bad;
  } fmt_char_t;

  localparam int NUM_DIRECTED = 25;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [rnf_pkg::ValueW-1:0] in_value = '0;
  logic [rnf_pkg::RadixW-1:0] in_radix = '0;
  logic [rnf_pkg::FieldW-1:0] in_field_width = '0;
  logic [rnf_pkg::FieldW-1:0] in_min_digits = '0;
  logic [rnf_pkg::FlagsW-1:0] in_flags = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [rnf_pkg::CharW-1:0] out_char;
  logic out_last;
  logic out_bad_radix;

  fmt_char_t   pending_chars [$];
  dir_row_t    dir_table [NUM_DIRECTED];
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;
  int unsigned rx_hold = 0;
  logic        tx_calm = 1'b0;

  radix_number_formatter_top #(
    .MAX_FIELD(MAX_FIELD)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .in_radix      (in_radix),
    .in_field_width(in_field_width),
    .in_min_digits (in_min_digits),
    .in_flags      (in_flags),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .out_last      (out_last),
    .out_bad_radix (out_bad_radix)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Mostly no gap, some short ones and a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) begin
      return 0;
    end else if (roll < 9) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Expands one number into its characters and queues them.
  function automatic void format_number(input fmt_req_t r);
    logic [rnf_pkg::ValueW-1:0] mag;
    logic [rnf_pkg::FlagsW-1:0] fl;
    logic [rnf_pkg::CharW-1:0]  sgn;
    logic [rnf_pkg::DigitW-1:0] digs [32];
    logic [rnf_pkg::CharW-1:0]  line [$];
    logic [rnf_pkg::DigitW-1:0] d;
    int                         w, p, nd, room, pad, pfx, i;
    fmt_char_t                  fc;

    if (r.radix < rnf_pkg::RadixMin || r.radix > rnf_pkg::RadixMax) begin
      fc.ch = rnf_pkg::ChNone;
      fc.last = 1'b1;
      fc.bad = 1'b1;
      pending_chars.push_back(fc);
      return;
    end

    fl = r.flags;
    w = (int'(r.width) > MAX_FIELD) ? MAX_FIELD : int'(r.width);
    p = (int'(r.digits) > MAX_FIELD) ? MAX_FIELD : int'(r.digits);
    if (fl & F_LEFT) fl &= ~F_ZERO;

    mag = r.value;
    sgn = rnf_pkg::ChNone;
    if ((fl & F_SIGNED) && mag[rnf_pkg::ValueW-1]) begin
      sgn = rnf_pkg::ChMinus;
      mag = rnf_pkg::ValueW'(0) - mag;
    end else if (fl & F_PLUS) begin
      sgn = rnf_pkg::ChPlus;
    end else if (fl & F_SPACE) begin
      sgn = rnf_pkg::ChSpace;
    end

    pfx = 0;
    if (fl & F_PREFIX) begin
      if (r.radix == rnf_pkg::RadixHex) pfx = 2;
      else if (r.radix == rnf_pkg::RadixOct) pfx = 1;
    end
    room = w - pfx - ((sgn != rnf_pkg::ChNone) ? 1 : 0);

    nd = 0;
    do begin
      digs[nd] = rnf_pkg::DigitW'(mag % rnf_pkg::ValueW'(r.radix));
      mag = mag / rnf_pkg::ValueW'(r.radix);
      nd++;
    end while (mag != 0 && nd < 32);

    if (nd > p) p = nd;
    room -= p;
    pad = (room > 0) ? room : 0;

    if ((fl & (F_ZERO | F_LEFT)) == F_NONE) begin
      for (i = 0; i < pad; i++) line.push_back(rnf_pkg::ChSpace);
      pad = 0;
    end
    if (sgn != rnf_pkg::ChNone) line.push_back(sgn);
    if (pfx > 0) line.push_back(rnf_pkg::ChZero);
    if (pfx > 1) line.push_back((fl & F_LOWER) ? rnf_pkg::ChLowX : rnf_pkg::ChUpX);
    if (!(fl & F_LEFT)) begin
      for (i = 0; i < pad; i++) line.push_back(rnf_pkg::ChZero);
      pad = 0;
    end
    for (i = nd; i < p; i++) line.push_back(rnf_pkg::ChZero);
    for (i = nd - 1; i >= 0; i--) begin
      d = digs[i];
      if (d < 10) begin
        line.push_back(rnf_pkg::ChZero + rnf_pkg::CharW'(d));
      end else begin
        line.push_back(((fl & F_LOWER) ? CH_LOW_A : CH_UP_A) + rnf_pkg::CharW'(d - 10));
      end
    end
    for (i = 0; i < pad; i++) line.push_back(rnf_pkg::ChSpace);

    for (i = 0; i < line.size(); i++) begin
      fc.ch = line[i];
      fc.last = (i == line.size() - 1);
      fc.bad = 1'b0;
      pending_chars.push_back(fc);
    end
  endfunction

  // Presents one number, waits for acceptance and queues what it must give.
  task automatic send_number(input fmt_req_t r, input check_kind_t kind,
                             input string text);
    int unsigned gap;
    int          i;
    fmt_char_t   fc;

    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_value       <= r.value;
    in_radix       <= r.radix;
    in_field_width <= r.width;
    in_min_digits  <= r.digits;
    in_flags       <= r.flags;
    do @(posedge clk); while (in_ready !== 1'b1);

    case (kind)
      CHK_PREDICT: begin
        format_number(r);
      end
      CHK_BAD_RADIX: begin
        fc.ch = rnf_pkg::ChNone;
        fc.last = 1'b1;
        fc.bad = 1'b1;
        pending_chars.push_back(fc);
      end
      default: begin
        for (i = 0; i < text.len(); i++) begin
          fc.ch = text[i];
          fc.last = (i == text.len() - 1);
          fc.bad = 1'b0;
          pending_chars.push_back(fc);
        end
      end
    endcase
  endtask

  // Receiver pacing, with calm stretches where it starts no new stall.
  always @(posedge clk) begin : rx_pace
    int unsigned g;
    g = (((cycle_cnt / 500) % 5) == 2) ? 0 : pick_gap();
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= 1'b0;
    end else if (g == 0) begin
      out_ready <= 1'b1;
    end else begin
      rx_hold <= g - 1;
      out_ready <= 1'b0;
    end
  end

  always @(posedge clk) begin : char_check
    fmt_char_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected char, expected none, got char %h last %b bad %b",
                 $time, out_char, out_last, out_bad_radix);
      end else begin
        e = pending_chars.pop_front();
        if (out_char !== e.ch || out_last !== e.last || out_bad_radix !== e.bad) begin
          mismatches++;
          $display("%0t: mismatch, expected char %h last %b bad %b, got char %h last %b bad %b",
                   $time, e.ch, e.last, e.bad, out_char, out_last, out_bad_radix);
        end
      end
    end
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("%0t: timeout with %0d chars outstanding", $time, pending_chars.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    fmt_req_t r;
    int       k;
    int       roll;

    dir_table = '{
      '{32'h0000_0000, 6'd10, 6'd0,  6'd0,  F_NONE, CHK_TEXT, "0"},
      '{32'hFFFF_FFFF, 6'd10, 6'd0,  6'd0,  F_NONE, CHK_TEXT, "4294967295"},
      '{32'hFFFF_FFFF, 6'd10, 6'd0,  6'd0,  F_SIGNED, CHK_TEXT, "-1"},
      '{32'h8000_0000, 6'd10, 6'd0,  6'd0,  F_SIGNED, CHK_TEXT, "-2147483648"},
      '{32'hFFFF_FFFF, 6'd2,  6'd0,  6'd0,  F_NONE, CHK_PREDICT, ""},
      '{32'hFFFF_FFFF, 6'd36, 6'd0,  6'd0,  F_NONE, CHK_TEXT, "1Z141Z3"},
      '{32'd35,        6'd36, 6'd0,  6'd0,  F_LOWER, CHK_TEXT, "z"},
      '{32'd123,       6'd0,  6'd0,  6'd0,  F_NONE, CHK_BAD_RADIX, ""},
      '{32'd123,       6'd1,  6'd5,  6'd5,  F_PLUS, CHK_BAD_RADIX, ""},
      '{32'd123,       6'd37, 6'd0,  6'd0,  F_PREFIX, CHK_BAD_RADIX, ""},
      '{32'hFFFF_FFFF, 6'd63, 6'd63, 6'd63, F_ALL, CHK_BAD_RADIX, ""},
      '{32'd255,       6'd16, 6'd0,  6'd0,  F_PREFIX, CHK_TEXT, "0XFF"},
      '{32'd255,       6'd16, 6'd0,  6'd0,  F_PREFIX | F_LOWER, CHK_TEXT, "0xff"},
      '{32'd0,         6'd8,  6'd0,  6'd0,  F_PREFIX, CHK_TEXT, "00"},
      '{32'd255,       6'd16, 6'd8,  6'd0,  F_PREFIX | F_ZERO, CHK_TEXT, "0X0000FF"},
      '{32'd42,        6'd10, 6'd6,  6'd0,  F_NONE, CHK_TEXT, "    42"},
      '{32'd42,        6'd10, 6'd6,  6'd0,  F_ZERO, CHK_TEXT, "000042"},
      '{32'd42,        6'd10, 6'd6,  6'd0,  F_LEFT | F_ZERO, CHK_TEXT, "42    "},
      '{32'hFFFF_FFFF, 6'd10, 6'd0,  6'd0,  F_PLUS, CHK_TEXT, "+4294967295"},
      '{32'd7,         6'd10, 6'd4,  6'd0,  F_SPACE, CHK_TEXT, "   7"},
      '{32'd42,        6'd10, 6'd8,  6'd5,  F_NONE, CHK_TEXT, "   00042"},
      '{32'd12345,     6'd10, 6'd2,  6'd0,  F_NONE, CHK_TEXT, "12345"},
      '{32'hFFFF_FFFF, 6'd16, 6'd63, 6'd63, F_PLUS | F_PREFIX, CHK_PREDICT, ""},
      '{32'd1,         6'd10, 6'd63, 6'd0,  F_LEFT, CHK_PREDICT, ""},
      '{32'h8000_0000, 6'd16, 6'd20, 6'd0,  F_ALL, CHK_PREDICT, ""}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[i]) begin
      r.value  = dir_table[i].value;
      r.radix  = dir_table[i].radix;
      r.width  = dir_table[i].width;
      r.digits = dir_table[i].digits;
      r.flags  = dir_table[i].flags;
      send_number(r, dir_table[i].kind, dir_table[i].text);
    end

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      tx_calm = (((k / 40) % 4) == 3);

      roll = $urandom_range(0, 9);
      if (roll < 4) r.value = $urandom();
      else if (roll < 6) r.value = $urandom_range(0, 1000);
      else if (roll == 6) r.value = '0;
      else if (roll == 7) r.value = '1;
      else if (roll == 8) r.value = 32'h8000_0000 | $urandom_range(0, 255);
      else r.value = rnf_pkg::ValueW'(0) - rnf_pkg::ValueW'($urandom_range(1, 1000));

      // Bad radices are kept rare so most items exercise the divider.
      roll = $urandom_range(0, 19);
      if (roll == 0) r.radix = rnf_pkg::RadixW'($urandom_range(0, 1));
      else if (roll == 1) r.radix = rnf_pkg::RadixW'($urandom_range(37, 63));
      else if (roll < 4) r.radix = rnf_pkg::RadixHex;
      else if (roll == 4) r.radix = rnf_pkg::RadixOct;
      else if (roll < 8) r.radix = 6'd10;
      else if (roll == 8) r.radix = rnf_pkg::RadixMin;
      else if (roll == 9) r.radix = rnf_pkg::RadixMax;
      else r.radix = rnf_pkg::RadixW'($urandom_range(2, 36));

      roll = $urandom_range(0, 19);
      if (roll < 16) r.width = rnf_pkg::FieldW'($urandom_range(0, 16));
      else if (roll < 19) r.width = rnf_pkg::FieldW'($urandom_range(17, MAX_FIELD));
      else r.width = rnf_pkg::FieldW'($urandom_range(MAX_FIELD + 1, 63));

      roll = $urandom_range(0, 19);
      if (roll < 16) r.digits = rnf_pkg::FieldW'($urandom_range(0, 12));
      else if (roll < 19) r.digits = rnf_pkg::FieldW'($urandom_range(13, MAX_FIELD));
      else r.digits = rnf_pkg::FieldW'($urandom_range(MAX_FIELD + 1, 63));

      r.flags = rnf_pkg::FlagsW'($urandom_range(0, 127));
      send_number(r, CHK_PREDICT, "");
    end
    in_valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
